[rtl/core/sac_pkg.sv]
// ----------------------------------------------------------------------------
// sac_pkg
// Types and constants shared by the swept box collision core.
// ----------------------------------------------------------------------------
package sac_pkg;

    localparam int CB = 24;
    localparam int TF = 16;
    localparam int TB = TF + 8;
    localparam int DB = CB + 2;          // edge distance width
    localparam int QB = DB + TF;         // quotient magnitude width
    localparam logic [15:0] TOL_RESET = 16'd512;

    typedef struct packed {
        logic signed [CB-1:0] a_left;
        logic signed [CB-1:0] a_top;
        logic [CB-2:0]        a_width;
        logic [CB-2:0]        a_height;
        logic signed [CB-1:0] a_vel_x;
        logic signed [CB-1:0] a_vel_y;
        logic signed [CB-1:0] b_left;
        logic signed [CB-1:0] b_top;
        logic [CB-2:0]        b_width;
        logic [CB-2:0]        b_height;
        logic [TB-1:0]        frame_time;
    } in_item_t;

    typedef struct packed {
        logic [TB-1:0] entry_time;
        logic [1:0]    normal_x;
        logic [1:0]    normal_y;
    } out_item_t;

    // classified flags produced by the front end
    typedef struct packed {
        logic xov;
        logic yov;
        logic touch;      // boxes overlap edges included
        logic nb_down;    // A bottom near B top
        logic nb_up;      // A top near B bottom
        logic nb_right;   // A right near B left, inclusive
        logic nb_left_i;  // A left near B right, inclusive
        logic nb_left_x;  // A left near B right, strict
        logic vx_pos;
        logic vx_zero;
        logic vy_pos;
        logic vy_zero;
        logic [TB-1:0] ft;
    } cls_t;

    // division job: numerator distances and velocities
    typedef struct packed {
        cls_t                 cls;
        logic signed [DB-1:0] xin;
        logic signed [DB-1:0] xout;
        logic signed [DB-1:0] yin;
        logic signed [DB-1:0] yout;
        logic signed [CB-1:0] vx;
        logic signed [CB-1:0] vy;
    } job_t;

    localparam int JOB_W = $bits(job_t);

endpackage

[rtl/core/swept_aabb_collision_core.sv]
// ----------------------------------------------------------------------------
// swept_aabb_collision_core
// Swept box collision test, one pair per cycle while full is low.
//
// channel  | direction | handshake      | payload
// input    | in        | push / full    | in_item (sac_pkg::in_item_t)
// result   | out       | pop / empty    | out_item (sac_pkg::out_item_t)
// config   | in        | tol_we         | tol_wdata (contact tolerance)
//
// One pair is accepted per cycle while full is low. Empty falls once the
// accepted pair has passed the front stage, divider load, 42 divider stages,
// resolve stage, queue write, queue read and output register.
// Reset clears all valid flags and loads the tolerance with TOL_RESET (512).
// The pipeline never stalls; full rises when the output queue cannot take
// the items still in flight.
// ----------------------------------------------------------------------------
module swept_aabb_collision_core #(
    parameter int QDEPTH = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  sac_pkg::in_item_t   in_item,
    output logic                empty,
    input  logic                pop,
    output sac_pkg::out_item_t  out_item,
    input  logic                tol_we,
    input  logic [15:0]         tol_wdata
);
    import sac_pkg::*;

    localparam int AW = $clog2(QDEPTH);

    logic [15:0] tol_reg;
    logic job_valid, res_valid;
    job_t job;
    out_item_t res, rd_data;
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0] cnt_reg, infl_reg, ram_cnt_reg;
    logic [AW:0] cnt_next, infl_next, ram_cnt_next;
    logic acc, deq, load, head_free;
    logic rd_ok_reg, head_v_reg, skid_v_reg;
    logic head_v_next, skid_v_next;
    logic [1:0] lvl;
    out_item_t head_reg, skid_reg;

    // write the tolerance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= TOL_RESET;
        else if (tol_we)
            tol_reg <= tol_wdata;
    end

    assign acc = push && !full;
    assign full = (AW+1)'(cnt_reg + infl_reg) >= (AW+1)'(QDEPTH);

    sac_front u_front (
        .clk, .rst_n, .in_valid(acc), .item(in_item), .tol(tol_reg),
        .stall(1'b0), .job_valid, .job
    );

    sac_back u_back (
        .clk, .rst_n, .en(1'b1), .job_valid, .job, .res_valid, .res
    );

    sac_ram #(.WIDTH($bits(out_item_t)), .DEPTH(QDEPTH)) u_q (
        .clk, .we(res_valid), .waddr(wp_reg), .wdata(res),
        .raddr(rp_reg), .rdata(rd_data)
    );

    // queue bookkeeping: cnt covers memory, pending read and the two-entry
    // output stage; reads are issued while the output stage has a free slot
    assign deq = pop && head_v_reg;
    assign head_free = !head_v_reg || deq;
    assign lvl = 2'(head_v_reg) + 2'(skid_v_reg) + 2'(rd_ok_reg) - 2'(deq);
    assign load = (ram_cnt_reg != '0) && (lvl < 2'd2);
    always_comb
    begin
        infl_next = infl_reg + (AW+1)'(acc) - (AW+1)'(res_valid);
        cnt_next = cnt_reg + (AW+1)'(res_valid) - (AW+1)'(deq);
        ram_cnt_next = ram_cnt_reg + (AW+1)'(res_valid) - (AW+1)'(load);
        head_v_next = head_free ? (skid_v_reg || rd_ok_reg) : 1'b1;
        skid_v_next = head_free ? (skid_v_reg && rd_ok_reg) : (skid_v_reg || rd_ok_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
            infl_reg <= '0;
            ram_cnt_reg <= '0;
            rd_ok_reg <= 1'b0;
            head_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            infl_reg <= infl_next;
            cnt_reg <= cnt_next;
            ram_cnt_reg <= ram_cnt_next;
            if (res_valid)
                wp_reg <= (wp_reg == AW'(QDEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (load)
                rp_reg <= (rp_reg == AW'(QDEPTH - 1)) ? '0 : rp_reg + 1'b1;
            rd_ok_reg <= load;
            head_v_reg <= head_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    // hold the head result, park a read that arrives while the head waits
    always_ff @(posedge clk)
    begin
        if (head_free)
        begin
            if (skid_v_reg)
                head_reg <= skid_reg;
            else if (rd_ok_reg)
                head_reg <= rd_data;
        end
        if (rd_ok_reg && (skid_v_reg || !head_free))
            skid_reg <= rd_data;
    end

    assign empty = !head_v_reg;
    assign out_item = head_reg;
endmodule

[rtl/core/sac_ram.sv]
// ----------------------------------------------------------------------------
// sac_ram
// Generic memory, one write port, one registered read port.
// ----------------------------------------------------------------------------
module sac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule

[rtl/core/sac_front.sv]
// ----------------------------------------------------------------------------
// sac_front
// Computes box edges, overlap and contact flags and the four distances.
// One registered stage.
// ----------------------------------------------------------------------------
module sac_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  sac_pkg::in_item_t    item,
    input  logic [15:0]          tol,
    input  logic                 stall,
    output logic                 job_valid,
    output sac_pkg::job_t        job
);
    import sac_pkg::*;

    logic signed [DB-1:0] al, at, ar, ab, bl, bt, br, bb;
    logic signed [DB-1:0] tl;
    logic signed [DB-1:0] d_down, d_up, d_right, d_left;
    job_t job_next, job_reg;
    logic valid_reg;

    function automatic logic signed [DB-1:0] sabs(input logic signed [DB-1:0] v);
        sabs = v[DB-1] ? -v : v;
    endfunction

    // classify the pair
    always_comb
    begin
        al = DB'(item.a_left);
        at = DB'(item.a_top);
        ar = al + DB'({1'b0, item.a_width});
        ab = at - DB'({1'b0, item.a_height});
        bl = DB'(item.b_left);
        bt = DB'(item.b_top);
        br = bl + DB'({1'b0, item.b_width});
        bb = bt - DB'({1'b0, item.b_height});
        tl = DB'({1'b0, tol});
        d_down  = sabs(ab - bt);
        d_up    = sabs(at - bb);
        d_right = sabs(ar - bl);
        d_left  = sabs(al - br);
        job_next.cls.xov = !(ar <= bl || al >= br);
        job_next.cls.yov = !(ab >= bt || at <= bb);
        job_next.cls.touch = !(al > br || at < bb || ar < bl || ab > bt);
        job_next.cls.nb_down   = d_down <= tl;
        job_next.cls.nb_up     = d_up <= tl;
        job_next.cls.nb_right  = d_right <= tl;
        job_next.cls.nb_left_i = d_left <= tl;
        job_next.cls.nb_left_x = d_left < tl;
        job_next.cls.vx_pos  = !item.a_vel_x[CB-1] && (item.a_vel_x != '0);
        job_next.cls.vx_zero = item.a_vel_x == '0;
        job_next.cls.vy_pos  = !item.a_vel_y[CB-1] && (item.a_vel_y != '0);
        job_next.cls.vy_zero = item.a_vel_y == '0;
        job_next.cls.ft = item.frame_time;
        if (job_next.cls.vx_pos)
        begin
            job_next.xin = bl - ar;
            job_next.xout = br - al;
        end
        else
        begin
            job_next.xin = br - al;
            job_next.xout = bl - ar;
        end
        if (job_next.cls.vy_pos)
        begin
            job_next.yin = bb - at;
            job_next.yout = bt - ab;
        end
        else
        begin
            job_next.yin = bt - ab;
            job_next.yout = bb - at;
        end
        job_next.vx = item.a_vel_x;
        job_next.vy = item.a_vel_y;
    end

    // advance unless the back end holds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            job_reg <= job_next;
        end
    end

    assign job_valid = valid_reg;
    assign job = job_reg;
endmodule

[rtl/core/sac_div.sv]
// ----------------------------------------------------------------------------
// sac_div
// Pipelined restoring divider, one quotient bit per stage, floor rounding.
// Computes (num << TF) / den for signed num and den, den nonzero.
// ----------------------------------------------------------------------------
module sac_div (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [sac_pkg::DB-1:0] num,
    input  logic signed [sac_pkg::CB-1:0] den,
    output logic signed [sac_pkg::QB:0]   quo
);
    import sac_pkg::*;

    localparam int NS = QB;

    logic [QB-1:0] n_reg [NS+1];
    logic [CB-1:0] d_reg [NS+1];
    logic [CB:0]   r_reg [NS+1];
    logic          neg_reg [NS+1];
    logic [DB-1:0] mag_n;
    logic [CB-1:0] mag_d;
    logic [QB:0]   qext;
    logic          round_up;

    assign mag_n = num[DB-1] ? DB'(-num) : DB'(num);
    assign mag_d = den[CB-1] ? CB'(-den) : CB'(den);

    // load first stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg[0]   <= {mag_n, TF'(0)};
            d_reg[0]   <= mag_d;
            r_reg[0]   <= '0;
            neg_reg[0] <= num[DB-1] ^ den[CB-1];
        end
    end

    // one bit per stage: shift in next numerator bit, subtract if fits
    for (genvar s = 0; s < NS; s++)
    begin : g_st
        logic [CB+1:0] trial;
        logic [CB+1:0] diff;
        assign trial = {r_reg[s], n_reg[s][QB-1]};
        assign diff  = trial - {2'b00, d_reg[s]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[s+1]   <= {n_reg[s][QB-2:0], ~diff[CB+1]};
                r_reg[s+1]   <= diff[CB+1] ? trial[CB:0] : diff[CB:0];
                d_reg[s+1]   <= d_reg[s];
                neg_reg[s+1] <= neg_reg[s];
            end
        end
    end

    // apply sign with floor rounding
    always_comb
    begin
        round_up = neg_reg[NS] && (r_reg[NS] != '0);
        qext = {1'b0, n_reg[NS]} + (QB+1)'(round_up);
        quo = neg_reg[NS] ? -$signed(qext) : $signed(qext);
    end
endmodule

[rtl/core/sac_back.sv]
// ----------------------------------------------------------------------------
// sac_back
// Four pipelined dividers give axis entry and exit times; a final stage
// resolves hit or miss, picks normals and saturates the entry time.
// ----------------------------------------------------------------------------
module sac_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               job_valid,
    input  sac_pkg::job_t      job,
    output logic               res_valid,
    output sac_pkg::out_item_t res
);
    import sac_pkg::*;

    localparam int LAT = QB + 1;
    localparam int TW  = QB + 2;   // time width incl. infinity range

    logic signed [QB:0] qxen, qxex, qyen, qyex;
    cls_t cls_d [LAT];
    logic v_d [LAT];
    logic signed [TW-1:0] xen, xex, yen, yex, entry, exitt, ftw;
    logic signed [TW-1:0] big;
    logic [1:0] nx, ny;
    logic miss;
    out_item_t res_reg;
    logic rv_reg;

    sac_div u_xen (.clk, .en, .num(job.xin),  .den(job.vx), .quo(qxen));
    sac_div u_xex (.clk, .en, .num(job.xout), .den(job.vx), .quo(qxex));
    sac_div u_yen (.clk, .en, .num(job.yin),  .den(job.vy), .quo(qyen));
    sac_div u_yex (.clk, .en, .num(job.yout), .den(job.vy), .quo(qyex));

    // delay classification alongside the dividers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cls_d[0] <= job.cls;
            for (int i = 0; i < LAT-1; i++)
            begin
                cls_d[i+1] <= cls_d[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
            begin
                v_d[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_d[0] <= job_valid;
            for (int i = 0; i < LAT-1; i++)
            begin
                v_d[i+1] <= v_d[i];
            end
        end
    end

    // resolve hit and normals
    always_comb
    begin
        big = {2'b01, (TW-2)'(0)};
        xen = cls_d[LAT-1].vx_zero ? -big : TW'(qxen);
        xex = cls_d[LAT-1].vx_zero ?  big : TW'(qxex);
        yen = cls_d[LAT-1].vy_zero ? -big : TW'(qyen);
        yex = cls_d[LAT-1].vy_zero ?  big : TW'(qyex);
        ftw = TW'({1'b0, cls_d[LAT-1].ft});
        entry = (xen > yen) ? xen : yen;
        exitt = (xex < yex) ? xex : yex;
        nx = 2'd0;
        ny = 2'd0;
        miss = entry > exitt || (xen[TW-1] && yen[TW-1]) || xen > ftw || yen > ftw;
        if (miss)
        begin
            entry = '0;
            if (cls_d[LAT-1].touch)
            begin
                if (cls_d[LAT-1].nb_down && cls_d[LAT-1].xov)
                    ny = 2'd1;
                else if (cls_d[LAT-1].nb_up && cls_d[LAT-1].xov)
                    ny = 2'd2;
                else if (cls_d[LAT-1].nb_right && cls_d[LAT-1].yov)
                    nx = 2'd1;
                else if (cls_d[LAT-1].nb_left_i && cls_d[LAT-1].yov)
                    nx = 2'd2;
                else if (cls_d[LAT-1].xov && cls_d[LAT-1].yov)
                begin
                    nx = 2'd3;
                    ny = 2'd3;
                end
            end
        end
        else if (xen > yen)
        begin
            if (cls_d[LAT-1].yov)
                nx = cls_d[LAT-1].vx_pos ? 2'd1 : 2'd2;
            else if (cls_d[LAT-1].nb_down)
            begin
                ny = 2'd1;
                entry = '0;
            end
            else if (cls_d[LAT-1].nb_up)
            begin
                ny = 2'd2;
                entry = '0;
            end
        end
        else
        begin
            if (cls_d[LAT-1].xov)
                ny = cls_d[LAT-1].vy_pos ? 2'd2 : 2'd1;
            else if (cls_d[LAT-1].nb_right)
            begin
                nx = 2'd1;
                entry = '0;
            end
            else if (cls_d[LAT-1].nb_left_x)
            begin
                nx = 2'd2;
                entry = '0;
            end
        end
    end

    // register result with saturation
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (entry[TW-1])
                res_reg.entry_time <= '0;
            else if (entry > TW'({1'b0, {TB{1'b1}}}))
                res_reg.entry_time <= '1;
            else
                res_reg.entry_time <= entry[TB-1:0];
            res_reg.normal_x <= nx;
            res_reg.normal_y <= ny;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rv_reg <= 1'b0;
        else if (en)
            rv_reg <= v_d[LAT-1];
    end

    assign res_valid = rv_reg;
    assign res = res_reg;
endmodule
